### sv/mcr_pkg.sv
// shared types and constants for the midpoint circle rasterizer
package mcr_pkg;

  // operation codes carried on the input tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // fixed field widths
  localparam int DEPTH_BITS = 16;
  localparam int COLOR_BITS = 24;

  // decision variable constants
  localparam int DEC_INIT     = 3;
  localparam int DEC_INC_KEEP = 6;
  localparam int DEC_INC_STEP = 10;

  // pixel sequence positions within one step
  localparam logic [3:0] K_FIRST_OCT  = 4'd0;
  localparam logic [3:0] K_LAST_OCT   = 4'd7;
  localparam logic [3:0] K_FIRST_DIAG = 4'd8;
  localparam logic [3:0] K_LAST_DIAG  = 4'd11;

  // what one step hands to the pixel emitter
  typedef struct packed {
    logic octants;
    logic diag;
    logic done;
  } mcr_step_t;

endpackage

### sv/mcr_emit.sv
// pixel emitter: holds one step's work, sends its pixels one beat per cycle unless stalled
module mcr_emit #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  mcr_pkg::mcr_step_t                 step,
  input  logic signed [COORD_BITS-1:0]       cx,
  input  logic signed [COORD_BITS-1:0]       cy,
  input  logic signed [mcr_pkg::DEPTH_BITS-1:0] depth,
  input  logic [mcr_pkg::COLOR_BITS-1:0]     color,
  input  logic [RADIUS_BITS-1:0]             ox,
  input  logic [RADIUS_BITS-1:0]             oy,
  input  logic [RADIUS_BITS-1:0]             nx,
  output logic                               ready,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // pixel_x, pixel_y, depth_out, color_out
  output logic [((2*(COORD_BITS+1)+mcr_pkg::DEPTH_BITS+mcr_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
  output logic                               m_tlast,
  // circle_done
  output logic                               m_tuser
);
  import mcr_pkg::*;

  localparam int PW    = COORD_BITS + 1;
  localparam int OW    = (RADIUS_BITS > PW) ? RADIUS_BITS : PW;
  localparam int OUT_W = ((2*PW + DEPTH_BITS + COLOR_BITS + 7) / 8) * 8;

  logic                          busy;
  logic [3:0]                    k;
  logic [3:0]                    kend;
  logic                          done;
  logic signed [COORD_BITS-1:0]  bcx;
  logic signed [COORD_BITS-1:0]  bcy;
  logic [DEPTH_BITS-1:0]         bdep;
  logic [COLOR_BITS-1:0]         bcol;
  logic [RADIUS_BITS-1:0]        bx;
  logic [RADIUS_BITS-1:0]        by;
  logic [RADIUS_BITS-1:0]        bn;

  logic [PW-1:0]                 px;
  logic [PW-1:0]                 py;
  logic [DEPTH_BITS-1:0]         odep;
  logic [COLOR_BITS-1:0]         ocol;

  logic                          advance;
  logic                          fin;
  logic [RADIUS_BITS-1:0]        a_sel;
  logic [RADIUS_BITS-1:0]        b_sel;
  logic [OW-1:0]                 a_wide;
  logic [OW-1:0]                 b_wide;
  logic [PW-1:0]                 a_ext;
  logic [PW-1:0]                 b_ext;
  logic [PW-1:0]                 cxe;
  logic [PW-1:0]                 cye;
  logic [PW-1:0]                 px_next;
  logic [PW-1:0]                 py_next;

  assign advance = busy && (!m_tvalid || m_tready);
  assign fin     = advance && (k == kend);
  assign ready   = !busy || fin;

  always_comb begin
    case (k[3:2])
      2'd0: begin
        a_sel = by;
        b_sel = bx;
      end
      2'd1: begin
        a_sel = bx;
        b_sel = by;
      end
      default: begin
        a_sel = bn;
        b_sel = bn;
      end
    endcase
    a_wide  = OW'(a_sel);
    b_wide  = OW'(b_sel);
    a_ext   = a_wide[PW-1:0];
    b_ext   = b_wide[PW-1:0];
    cxe     = PW'(bcx);
    cye     = PW'(bcy);
    px_next = k[0] ? (cxe - a_ext) : (cxe + a_ext);
    py_next = k[1] ? (cye - b_ext) : (cye + b_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (fin) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      k    <= step.octants ? K_FIRST_OCT : K_FIRST_DIAG;
      kend <= step.diag ? K_LAST_DIAG : K_LAST_OCT;
      done <= step.done;
      bcx  <= cx;
      bcy  <= cy;
      bdep <= depth;
      bcol <= color;
      bx   <= ox;
      by   <= oy;
      bn   <= nx;
    end else if (advance) begin
      k <= k + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      px      <= px_next;
      py      <= py_next;
      odep    <= bdep;
      ocol    <= bcol;
      m_tlast <= (k == kend);
      m_tuser <= (k == kend) && done;
    end
  end

  assign m_tdata = OUT_W'({ocol, odep, py, px});

endmodule

### sv/midpoint_circle_raster.sv
// midpoint circle rasterizer top level
// A start beat (tuser 0) loads center, depth, radius and color and sends
// nothing. Each step beat (tuser 1) walks one octant position and sends
// up to twelve pixel beats, one per cycle on the output port unless it
// stalls: eight octant pixels, plus four diagonal pixels on a step that
// reaches the diagonal (only those four for a zero radius circle). tlast
// marks the final pixel of a step and tuser the final pixel of the circle.
// The step logic runs in the accepting cycle and hands its pixels to a
// one-step buffer; the next beat is accepted in the cycle the previous
// step's last pixel leaves the buffer, paced by the single output pixel per
// cycle and stretched by any output stall. Start beats and steps while idle
// are accepted as soon as the buffer has room.
module midpoint_circle_raster #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // center_x, center_y, depth_in, radius, color_in
  input  logic [((2*COORD_BITS+mcr_pkg::DEPTH_BITS+RADIUS_BITS+mcr_pkg::COLOR_BITS+7)/8)*8-1:0]
               s_tdata,
  // op
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // pixel_x, pixel_y, depth_out, color_out
  output logic [((2*(COORD_BITS+1)+mcr_pkg::DEPTH_BITS+mcr_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
  // last_of_step
  output logic m_tlast,
  // circle_done
  output logic m_tuser
);
  import mcr_pkg::*;

  localparam int DW     = RADIUS_BITS + 4;
  localparam int CX_LO  = 0;
  localparam int CY_LO  = COORD_BITS;
  localparam int DEP_LO = 2*COORD_BITS;
  localparam int RAD_LO = DEP_LO + DEPTH_BITS;
  localparam int COL_LO = RAD_LO + RADIUS_BITS;

  logic                          active;
  logic [RADIUS_BITS-1:0]        cur_x;
  logic [RADIUS_BITS-1:0]        cur_y;
  logic [DW-1:0]                 decision;
  logic signed [COORD_BITS-1:0]  held_cx;
  logic signed [COORD_BITS-1:0]  held_cy;
  logic signed [DEPTH_BITS-1:0]  held_depth;
  logic [COLOR_BITS-1:0]         held_color;

  logic                          accept;
  logic                          is_step;
  logic                          lt;
  logic                          eq;
  logic [RADIUS_BITS-1:0]        x_next;
  logic [RADIUS_BITS-1:0]        y_next;
  logic [DW-1:0]                 decision_next;
  logic [DW-1:0]                 xd;
  logic [DW-1:0]                 yd;
  logic [RADIUS_BITS-1:0]        in_radius;
  logic                          load;
  mcr_step_t                     step;

  assign accept    = s_tvalid && s_tready;
  assign is_step   = (s_tuser == OP_STEP);
  assign in_radius = s_tdata[RAD_LO +: RADIUS_BITS];

  always_comb begin
    xd            = DW'(cur_x);
    yd            = DW'(cur_y);
    lt            = cur_x < cur_y;
    x_next        = cur_x;
    y_next        = cur_y;
    decision_next = decision;
    if (lt) begin
      x_next = cur_x + RADIUS_BITS'(1);
      if (decision[DW-1]) begin
        decision_next = decision + (xd << 2) + DW'(DEC_INC_KEEP);
      end else begin
        decision_next = decision + ((xd - yd) << 2) + DW'(DEC_INC_STEP);
        y_next        = cur_y - RADIUS_BITS'(1);
      end
    end
    eq           = x_next == y_next;
    step.octants = lt;
    step.diag    = eq;
    step.done    = !(x_next < y_next);
  end

  assign load = accept && is_step && active && (lt || eq);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      if (!is_step) begin
        active <= 1'b1;
      end else if (active) begin
        active <= x_next < y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!is_step) begin
        held_cx    <= s_tdata[CX_LO +: COORD_BITS];
        held_cy    <= s_tdata[CY_LO +: COORD_BITS];
        held_depth <= s_tdata[DEP_LO +: DEPTH_BITS];
        held_color <= s_tdata[COL_LO +: COLOR_BITS];
        cur_x      <= '0;
        cur_y      <= in_radius;
        decision   <= DW'(DEC_INIT) - (DW'(in_radius) << 1);
      end else if (active) begin
        cur_x    <= x_next;
        cur_y    <= y_next;
        decision <= decision_next;
      end
    end
  end

  mcr_emit #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .step     (step),
    .cx       (held_cx),
    .cy       (held_cy),
    .depth    (held_depth),
    .color    (held_color),
    .ox       (cur_x),
    .oy       (cur_y),
    .nx       (x_next),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

### sv/mcr_check.sv
// port checks for the midpoint circle rasterizer, bound to the top level
module mcr_check #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((2*(COORD_BITS+1)+mcr_pkg::DEPTH_BITS+mcr_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
  input logic m_tlast,
  input logic m_tuser
);

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat right after reset");

  // circle end is always the end of a step
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("circle_done without last_of_step");

  // mid-step stall keeps the input closed
  a_midstep_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !m_tlast |-> !s_tready)
    else $error("input ready while a step still has pixels pending");

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output beat changed while stalled");

endmodule

bind midpoint_circle_raster mcr_check #(
  .RADIUS_BITS (RADIUS_BITS),
  .COORD_BITS  (COORD_BITS)
) u_mcr_check (.*);

### verif/midpoint_circle_raster_test.sv
// self-checking testbench for the midpoint circle rasterizer: directed and random circles
module midpoint_circle_raster_test;
  import mcr_pkg::*;

  localparam int SW = 80;
  localparam int MW = 72;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic [15:0] depth;
    logic [23:0] color;
    logic last;
    logic done;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [SW-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MW-1:0] m_tdata;
  logic m_tlast;
  logic m_tuser;

  midpoint_circle_raster DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted circle state
  logic circle_on = 1'b0;
  logic signed [11:0] held_cx = '0;
  logic signed [11:0] held_cy = '0;
  logic [15:0] held_depth = '0;
  logic [23:0] held_color = '0;
  int walk_x = 0;
  int walk_y = 0;
  int decision = 0;

  pixel_t pending_pixels[$];
  int errors = 0;
  int beats_sent = 0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  int hold_left = 0;

  function automatic void push_pixel(int ax, int ay);
    pixel_t p;
    p.x = ax[12:0];
    p.y = ay[12:0];
    p.depth = held_depth;
    p.color = held_color;
    p.last = 1'b0;
    p.done = 1'b0;
    pending_pixels.push_back(p);
  endfunction

  function automatic void push_quad(int a, int b);
    int cx;
    int cy;
    cx = int'(held_cx);
    cy = int'(held_cy);
    push_pixel(cx + a, cy + b);
    push_pixel(cx - a, cy + b);
    push_pixel(cx + a, cy - b);
    push_pixel(cx - a, cy - b);
  endfunction

  function automatic void trace_step(logic op, logic [SW-1:0] d);
    int n;
    int x;
    int y;
    pixel_t p;
    n = 0;
    if (op == OP_START) begin
      held_cx = d[11:0];
      held_cy = d[23:12];
      held_depth = d[39:24];
      walk_y = int'(d[49:40]);
      held_color = d[73:50];
      walk_x = 0;
      decision = DEC_INIT - 2 * walk_y;
      circle_on = 1'b1;
      return;
    end
    if (!circle_on) return;
    x = walk_x;
    y = walk_y;
    if (x < y) begin
      push_quad(y, x);
      push_quad(x, y);
      n = 8;
      if (decision < 0) begin
        decision += 4 * x + DEC_INC_KEEP;
      end else begin
        decision += 4 * (x - y) + DEC_INC_STEP;
        y--;
      end
      x++;
      walk_x = x;
      walk_y = y;
    end
    if (x == y) begin
      push_quad(x, x);
      n += 4;
      circle_on = 1'b0;
    end else if (x > y) begin
      circle_on = 1'b0;
    end
    if (n > 0) begin
      p = pending_pixels.pop_back();
      p.last = 1'b1;
      p.done = !circle_on;
      pending_pixels.push_back(p);
    end
  endfunction

  function automatic logic [SW-1:0] pack_circle(logic [11:0] cx, logic [11:0] cy,
                                                logic [15:0] depth, logic [9:0] r,
                                                logic [23:0] color);
    return {6'b0, color, r, depth, cy, cx};
  endfunction

  function automatic logic [SW-1:0] random_circle(logic [9:0] r);
    return pack_circle(12'($urandom), 12'($urandom), 16'($urandom), r, 24'($urandom));
  endfunction

  task automatic send_beat(input logic op, input logic [SW-1:0] d);
    @(negedge clk);
    if (gaps_on) begin
      while ($urandom_range(99) < 28) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    trace_step(op, d);
    beats_sent++;
  endtask

  task automatic finish_circle();
    while (circle_on) send_beat(OP_STEP, random_circle(10'($urandom)));
  endtask

  task automatic wait_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // output side: random stalls plus a counted hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= !(stall_on && $urandom_range(99) < 28);
    end
  end

  always @(posedge clk) begin
    pixel_t e;
    logic signed [12:0] ax;
    logic signed [12:0] ay;
    if (!rst && m_tvalid && m_tready) begin
      ax = m_tdata[12:0];
      ay = m_tdata[25:13];
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected pixel x=%0d y=%0d", $time, ax, ay);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (ax !== e.x) begin
          $display("%0t pixel_x exp %0d got %0d", $time, e.x, ax);
          errors++;
        end
        if (ay !== e.y) begin
          $display("%0t pixel_y exp %0d got %0d", $time, e.y, ay);
          errors++;
        end
        if (m_tdata[41:26] !== e.depth) begin
          $display("%0t depth exp %h got %h", $time, e.depth, m_tdata[41:26]);
          errors++;
        end
        if (m_tdata[65:42] !== e.color) begin
          $display("%0t color exp %h got %h", $time, e.color, m_tdata[65:42]);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $display("%0t last_of_step exp %b got %b", $time, e.last, m_tlast);
          errors++;
        end
        if (m_tuser !== e.done) begin
          $display("%0t circle_done exp %b got %b", $time, e.done, m_tuser);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    // step with no circle loaded
    send_beat(OP_STEP, random_circle(10'd5));
    // largest radius at opposite corners, abandoned by the next start
    send_beat(OP_START, pack_circle(12'h7FF, 12'h800, 16'h7FFF, 10'h3FF, 24'hFFFFFF));
    repeat (3) send_beat(OP_STEP, '0);
    send_beat(OP_START, pack_circle(12'h800, 12'h7FF, 16'h8000, 10'h3FF, 24'h000000));
    repeat (3) send_beat(OP_STEP, {SW{1'b1}} >> 6);
    // zero radius gives only the diagonal pixels, then idle
    send_beat(OP_START, pack_circle(12'h7FF, 12'h7FF, 16'h0000, 10'd0, 24'hA5A5A5));
    send_beat(OP_STEP, '0);
    send_beat(OP_STEP, '0);
    // radius 3 closes on the diagonal, radius 1 closes past it
    send_beat(OP_START, pack_circle(12'h800, 12'h800, 16'h1234, 10'd3, 24'h5A5A5A));
    finish_circle();
    send_beat(OP_START, pack_circle(12'h000, 12'h000, 16'hFFFF, 10'd1, 24'h0F0F0F));
    finish_circle();
    wait_results();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    stall_on = 1'b0;
    repeat (3) begin
      send_beat(OP_START, random_circle(10'($urandom_range(0, 16))));
      finish_circle();
    end
    wait_results();
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    send_beat(OP_START, random_circle(10'd30));
    finish_circle();
    wait_results();
  endtask

  task automatic test_random();
    int r;
    int cap;
    int steps;
    while (beats_sent < 350) begin
      if ($urandom_range(99) < 12) begin
        send_beat(1'($urandom), random_circle(10'($urandom)));
      end else begin
        case ($urandom_range(9))
          0: r = $urandom_range(0, 1023);
          1, 2: r = $urandom_range(25, 120);
          default: r = $urandom_range(0, 24);
        endcase
        cap = ($urandom_range(99) < 20) ? $urandom_range(0, 6) : 40;
        steps = 0;
        send_beat(OP_START, random_circle(10'(r)));
        while (circle_on && steps < cap) begin
          send_beat(OP_STEP, random_circle(10'($urandom)));
          steps++;
        end
      end
    end
    wait_results();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = OP_START;
    s_tdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_back_to_back();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("[midpoint_circle_raster] OK");
    end else begin
      $display("[midpoint_circle_raster] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[midpoint_circle_raster] ERROR");
    $finish;
  end

endmodule

### filelist.f
sv/mcr_pkg.sv
sv/mcr_emit.sv
sv/midpoint_circle_raster.sv
sv/mcr_check.sv
verif/midpoint_circle_raster_test.sv
